@@ rtl/core/mfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types, widths, codes and field offsets for the motor fault
// supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

  // storage widths
  localparam int COUNT_WIDTH    = 16;
  localparam int POSITION_WIDTH = 16;

  // saturated magnitude of a position fits in one bit less than the position
  localparam int POS_ABS_W = POSITION_WIDTH - 1;
  localparam int POS_CMP_W = (POS_ABS_W > 16) ? POS_ABS_W : 16;
  localparam int CNT_CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  // check kinds
  localparam logic [2:0] OP_SPEED    = 3'd0;
  localparam logic [2:0] OP_VOLTAGE  = 3'd1;
  localparam logic [2:0] OP_CURRENT  = 3'd2;
  localparam logic [2:0] OP_POSITION = 3'd3;
  localparam logic [2:0] OP_TEMP     = 3'd4;

  // reported motor states
  localparam logic [1:0] ST_STOP    = 2'd0;
  localparam logic [1:0] ST_STARTUP = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_FAIL    = 2'd3;

  // fault bit positions
  localparam int F_STALL     = 0;
  localparam int F_OVERSPEED = 1;
  localparam int F_VOLTAGE   = 2;
  localparam int F_CURRENT   = 3;
  localparam int F_POSITION  = 4;
  localparam int F_TEMP      = 5;
  localparam int FAULT_W     = 6;

  // register indexes
  localparam logic [2:0] CFG_SLOW_RPM    = 3'd0;
  localparam logic [2:0] CFG_STALL_LIMIT = 3'd1;
  localparam logic [2:0] CFG_MAX_SPEED   = 3'd2;
  localparam logic [2:0] CFG_VOLT_MAX    = 3'd3;
  localparam logic [2:0] CFG_VOLT_MIN    = 3'd4;
  localparam logic [2:0] CFG_CURRENT_MAX = 3'd5;
  localparam logic [2:0] CFG_POS_MAX     = 3'd6;
  localparam logic [2:0] CFG_TEMP_MAX    = 3'd7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // input tdata layout, lowest field first
  localparam int IN_ST_LSB   = 0;
  localparam int IN_SPD_LSB  = 2;
  localparam int IN_VOLT_LSB = 18;
  localparam int IN_CU_LSB   = 34;
  localparam int IN_CV_LSB   = 50;
  localparam int IN_CW_LSB   = 66;
  localparam int IN_POS_LSB  = 82;
  localparam int IN_TEMP_LSB = IN_POS_LSB + POSITION_WIDTH;
  localparam int IN_BITS     = IN_TEMP_LSB + 9;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = FAULT_W + 3;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [14:0]        slow_rpm;
    logic [15:0]        stall_limit;
    logic [14:0]        max_speed;
    logic [15:0]        volt_max;
    logic [15:0]        volt_min;
    logic signed [15:0] current_max;
    logic [15:0]        pos_max;
    logic signed [8:0]  temp_max;
  } mfs_cfg_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] stall_count;
    logic [POS_ABS_W-1:0]   last_pos;
    logic                   last_valid;
    logic [FAULT_W-1:0]     faults;
  } mfs_state_t;

  typedef struct packed {
    logic [FAULT_W-1:0] fault_bits;
    logic               stop_request;
    logic               fail_request;
    logic               position_invalid;
  } mfs_result_t;

endpackage

`default_nettype wire

@@ rtl/core/mfs_check.sv @@
// ----------------------------------------------------------------------------
// mfs_check
// Check logic for one item: evaluates the selected check against the
// configuration and the supervisor state, gives the next state and result.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_check (
  input  var mfs_pkg::mfs_cfg_t               cfg,
  input  var mfs_pkg::mfs_state_t             st,
  input  wire  [2:0]                          operation,
  input  wire  [1:0]                          motor_state,
  input  wire  [15:0]                         speed_rpm,
  input  wire  [15:0]                         bus_voltage,
  input  wire  [15:0]                         current_u,
  input  wire  [15:0]                         current_v,
  input  wire  [15:0]                         current_w,
  input  wire  [mfs_pkg::POSITION_WIDTH-1:0]  encoder_position,
  input  wire  [8:0]                          board_temperature,
  output mfs_pkg::mfs_state_t                 st_nxt,
  output mfs_pkg::mfs_result_t                res
);

  logic [14:0]                      spd_abs;
  logic [mfs_pkg::POS_ABS_W-1:0]    pos_abs;
  logic [mfs_pkg::COUNT_WIDTH-1:0]  cnt_inc;
  logic                             running;
  logic                             pos_active;
  logic                             stop;
  logic                             fail;
  logic                             pinv;
  logic [mfs_pkg::FAULT_W-1:0]      faults;

  // magnitudes with the most negative value saturating
  always_comb begin
    if (speed_rpm == 16'h8000) begin
      spd_abs = '1;
    end else if (speed_rpm[15]) begin
      spd_abs = 15'((~speed_rpm) + 16'd1);
    end else begin
      spd_abs = speed_rpm[14:0];
    end
    if (encoder_position == {1'b1, {(mfs_pkg::POSITION_WIDTH-1){1'b0}}}) begin
      pos_abs = '1;
    end else if (encoder_position[mfs_pkg::POSITION_WIDTH-1]) begin
      pos_abs = mfs_pkg::POS_ABS_W'((~encoder_position) + 1'b1);
    end else begin
      pos_abs = encoder_position[mfs_pkg::POS_ABS_W-1:0];
    end
  end

  assign cnt_inc    = (&st.stall_count) ? st.stall_count : st.stall_count + 1'b1;
  assign running    = (motor_state == mfs_pkg::ST_RUNNING);
  assign pos_active = running || (motor_state == mfs_pkg::ST_STARTUP);

  always_comb begin
    st_nxt = st;
    faults = st.faults;
    stop   = 1'b0;
    fail   = 1'b0;
    pinv   = 1'b0;
    unique case (operation)
      mfs_pkg::OP_SPEED: begin
        if (running) begin
          if (spd_abs > cfg.slow_rpm) begin
            st_nxt.stall_count = '0;
          end else begin
            st_nxt.stall_count = cnt_inc;
            if (mfs_pkg::CNT_CMP_W'(cnt_inc) > mfs_pkg::CNT_CMP_W'(cfg.stall_limit)) begin
              faults[mfs_pkg::F_STALL] = 1'b1;
              fail = 1'b1;
            end
          end
          if (spd_abs > cfg.max_speed) begin
            faults[mfs_pkg::F_OVERSPEED] = 1'b1;
            fail = 1'b1;
          end
          stop = fail;
        end
      end
      mfs_pkg::OP_VOLTAGE: begin
        // voltage asks for a stop but never for the fail state
        if (bus_voltage > cfg.volt_max || bus_voltage < cfg.volt_min) begin
          faults[mfs_pkg::F_VOLTAGE] = 1'b1;
          stop = 1'b1;
        end
      end
      mfs_pkg::OP_CURRENT: begin
        if ($signed(current_u) >= $signed(cfg.current_max) ||
            $signed(current_v) >= $signed(cfg.current_max) ||
            $signed(current_w) >= $signed(cfg.current_max)) begin
          faults[mfs_pkg::F_CURRENT] = 1'b1;
          stop = 1'b1;
          fail = 1'b1;
        end
      end
      mfs_pkg::OP_POSITION: begin
        if (pos_active) begin
          if (mfs_pkg::POS_CMP_W'(pos_abs) > mfs_pkg::POS_CMP_W'(cfg.pos_max) ||
              (st.last_valid && pos_abs == st.last_pos)) begin
            faults[mfs_pkg::F_POSITION] = 1'b1;
            stop = 1'b1;
            fail = 1'b1;
            pinv = 1'b1;
          end
          st_nxt.last_pos   = pos_abs;
          st_nxt.last_valid = 1'b1;
        end
      end
      mfs_pkg::OP_TEMP: begin
        if ($signed(board_temperature) > $signed(cfg.temp_max)) begin
          faults[mfs_pkg::F_TEMP] = 1'b1;
          stop = 1'b1;
          fail = 1'b1;
        end
      end
      default: begin
        // unused check codes leave everything as is
      end
    endcase
    st_nxt.faults        = faults;
    res.fault_bits       = faults;
    res.stop_request     = stop;
    res.fail_request     = fail;
    res.position_invalid = pinv;
  end

endmodule

`default_nettype wire

@@ rtl/core/motor_fault_supervisor_top.sv @@
// an item is registered in the input stage and checked there; its result is
// registered in the result stage when the item leaves the check stage
// throughput: one item per cycle while results are taken, limited by the single check stage
// an item and its result register advance together; a stalled result holds
// the check stage, and a new item is still taken while the check stage is free
// reset (rst_n low, synchronous): both stages empty, faults and stall count
// cleared, no previous position, registers back to their default values
// ----------------------------------------------------------------------------
// motor_fault_supervisor_top
// Fault supervisor for a motor drive: one speed, voltage, current, position
// or temperature check per item, with sticky fault bits.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_fault_supervisor_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [mfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [mfs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // motor_state, speed_rpm, bus_voltage, current_u, current_v, current_w,
  // encoder_position, board_temperature, zero fill
  input  wire  [mfs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // operation
  input  wire  [2:0]                       in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // fault_bits, stop_request, fail_request, position_invalid, zero fill
  output logic [mfs_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  mfs_pkg::mfs_cfg_t    cfg_r;
  mfs_pkg::mfs_state_t  st_r;
  mfs_pkg::mfs_state_t  st_nxt;
  mfs_pkg::mfs_result_t res;

  logic                          s1_valid_r;
  logic [mfs_pkg::IN_BITS-1:0]   s1_data_r;
  logic [2:0]                    s1_op_r;
  logic                          out_free;
  logic                          s1_adv;
  logic                          out_valid_r;
  logic [mfs_pkg::OUT_BITS-1:0]  out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_rpm    <= 15'd100;
      cfg_r.stall_limit <= 16'd100;
      cfg_r.max_speed   <= 15'd30000;
      cfg_r.volt_max    <= 16'hFFFF;
      cfg_r.volt_min    <= 16'd0;
      cfg_r.current_max <= 16'sh7FFF;
      cfg_r.pos_max     <= 16'd3072;
      cfg_r.temp_max    <= 9'sd65;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfs_pkg::CFG_SLOW_RPM:    cfg_r.slow_rpm    <= cfg_data[14:0];
        mfs_pkg::CFG_STALL_LIMIT: cfg_r.stall_limit <= cfg_data;
        mfs_pkg::CFG_MAX_SPEED:   cfg_r.max_speed   <= cfg_data[14:0];
        mfs_pkg::CFG_VOLT_MAX:    cfg_r.volt_max    <= cfg_data;
        mfs_pkg::CFG_VOLT_MIN:    cfg_r.volt_min    <= cfg_data;
        mfs_pkg::CFG_CURRENT_MAX: cfg_r.current_max <= cfg_data;
        mfs_pkg::CFG_POS_MAX:     cfg_r.pos_max     <= cfg_data;
        mfs_pkg::CFG_TEMP_MAX:    cfg_r.temp_max    <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata[mfs_pkg::IN_BITS-1:0];
      s1_op_r   <= in_tuser;
    end
  end

  mfs_check u_check (
    .cfg               (cfg_r),
    .st                (st_r),
    .operation         (s1_op_r),
    .motor_state       (s1_data_r[mfs_pkg::IN_ST_LSB +: 2]),
    .speed_rpm         (s1_data_r[mfs_pkg::IN_SPD_LSB +: 16]),
    .bus_voltage       (s1_data_r[mfs_pkg::IN_VOLT_LSB +: 16]),
    .current_u         (s1_data_r[mfs_pkg::IN_CU_LSB +: 16]),
    .current_v         (s1_data_r[mfs_pkg::IN_CV_LSB +: 16]),
    .current_w         (s1_data_r[mfs_pkg::IN_CW_LSB +: 16]),
    .encoder_position  (s1_data_r[mfs_pkg::IN_POS_LSB +: mfs_pkg::POSITION_WIDTH]),
    .board_temperature (s1_data_r[mfs_pkg::IN_TEMP_LSB +: 9]),
    .st_nxt            (st_nxt),
    .res               (res)
  );

  // supervisor state moves only when the item leaves the check stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.stall_count <= '0;
      st_r.last_pos    <= '1;
      st_r.last_valid  <= 1'b0;
      st_r.faults      <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {res.position_invalid, res.fail_request, res.stop_request,
                     res.fault_bits};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mfs_pkg::OUT_TDATA_W'(out_data_r);

endmodule

`default_nettype wire

@@ rtl/core/mfs_checker.sv @@
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level assertions for the motor fault supervisor, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [mfs_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int STOP_BIT = mfs_pkg::FAULT_W;
  localparam int FAIL_BIT = mfs_pkg::FAULT_W + 1;
  localparam int PINV_BIT = mfs_pkg::FAULT_W + 2;

  // a stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // a fail request always comes with a stop request and a recorded fault
  a_fail_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FAIL_BIT] |->
      out_tdata[STOP_BIT] && (out_tdata[mfs_pkg::FAULT_W-1:0] != '0))
    else $error("fail request without stop or fault");

  // a bad position sets its fault bit and requests fail
  a_pinv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[PINV_BIT] |->
      out_tdata[FAIL_BIT] && out_tdata[mfs_pkg::F_POSITION])
    else $error("position invalid without position fault");

endmodule

bind motor_fault_supervisor_top mfs_checker u_mfs_checker (.*);

`default_nettype wire
